/* rtl/spi_nor_flash_command_sequencer_macros.svh */
// Assertion macros shared by the flash command sequencer modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SNFCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SNFCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/snfcs_pkg.sv */
// Package for the SPI NOR flash command sequencer: types, codes and defaults.
// Used by snfcs_seq, snfcs_emit and the top level; depends on nothing else.
package snfcs_pkg;

  // Field widths of the host and SPI sides.
  localparam int FUNC_W = 3;
  localparam int ADDR_W = 24;
  localparam int LEN_W  = 25;
  localparam int BYTE_W = 8;

  // Most results one item can cause, and the width of a count of them.
  localparam int MAX_RES = 12;
  localparam int CNT_W   = 4;

  // Read and write lengths saturate at this count.
  localparam logic [15:0] LEN_SAT = 16'hFFFF;

  // Bit of the status register that reads 1 while the flash is busy.
  localparam int STATUS_BUSY = 0;

  // Default geometry.
  localparam int DEF_PAGE_BYTES   = 256;
  localparam int DEF_SECTOR_BYTES = 4096;
  localparam int DEF_ADDR_BITS    = 24;

  // Configuration register indexes.
  localparam logic [2:0] REG_OP_READ_ID     = 3'd0;
  localparam logic [2:0] REG_OP_READ_STATUS = 3'd1;
  localparam logic [2:0] REG_OP_READ        = 3'd2;
  localparam logic [2:0] REG_OP_WRITE_EN    = 3'd3;
  localparam logic [2:0] REG_OP_PAGE_PROG   = 3'd4;
  localparam logic [2:0] REG_OP_SECTOR_ERA  = 3'd5;

  // Standard opcode defaults.
  localparam logic [7:0] DEF_OP_READ_ID     = 8'h9F;
  localparam logic [7:0] DEF_OP_READ_STATUS = 8'h05;
  localparam logic [7:0] DEF_OP_READ        = 8'h03;
  localparam logic [7:0] DEF_OP_WRITE_EN    = 8'h06;
  localparam logic [7:0] DEF_OP_PAGE_PROG   = 8'h02;
  localparam logic [7:0] DEF_OP_SECTOR_ERA  = 8'h20;

  // Host function codes.
  localparam logic [2:0] FN_READ_ID      = 3'd0;
  localparam logic [2:0] FN_READ         = 3'd1;
  localparam logic [2:0] FN_WRITE_START  = 3'd2;
  localparam logic [2:0] FN_WRITE_BYTE   = 3'd3;
  localparam logic [2:0] FN_ERASE_SECTOR = 3'd4;
  localparam logic [2:0] FN_ERASE_AREA   = 3'd5;
  localparam logic [2:0] FN_RX           = 3'd6;

  // SPI action codes.
  localparam logic [1:0] SPI_SEL = 2'd0;
  localparam logic [1:0] SPI_REL = 2'd1;
  localparam logic [1:0] SPI_OUT = 2'd2;
  localparam logic [1:0] SPI_IN  = 2'd3;

  // Host return kinds.
  localparam logic [2:0] HK_NONE   = 3'd0;
  localparam logic [2:0] HK_DATA   = 3'd1;
  localparam logic [2:0] HK_MANUF  = 3'd2;
  localparam logic [2:0] HK_DEV_HI = 3'd3;
  localparam logic [2:0] HK_DEV_LO = 3'd4;

  // Command phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID,
    PH_READ,
    PH_WDATA,
    PH_POLL_W,
    PH_POLL_E,
    PH_WEL
  } phase_t;

  // Opcode registers as one bundle.
  typedef struct packed {
    logic [7:0] rd_id;
    logic [7:0] rd_status;
    logic [7:0] rd;
    logic [7:0] wen;
    logic [7:0] pp;
    logic [7:0] se;
  } op_regs_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] sbyte;
    logic [2:0] hkind;
    logic [7:0] hbyte;
    logic       done;
    logic       last;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef res_t [MAX_RES-1:0] res_vec_t;

  // Results of one item handed from the sequencer to the result queue.
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] cnt;
    res_vec_t         list;
  } emit_load_t;

endpackage

/* rtl/snfcs_seq.sv */
// Sequencer: input register, command state and the result list of one item.
// Depends on snfcs_pkg and the assertion macro header.
`include "spi_nor_flash_command_sequencer_macros.svh"

module snfcs_seq #(
  parameter int PAGE_BYTES   = snfcs_pkg::DEF_PAGE_BYTES,
  parameter int SECTOR_BYTES = snfcs_pkg::DEF_SECTOR_BYTES,
  parameter int ADDR_BITS    = snfcs_pkg::DEF_ADDR_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  snfcs_pkg::op_regs_t            ops,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [snfcs_pkg::FUNC_W-1:0]   func,
  input  logic [snfcs_pkg::ADDR_W-1:0]   address,
  input  logic [snfcs_pkg::LEN_W-1:0]    length,
  input  logic [snfcs_pkg::BYTE_W-1:0]   data_byte,
  input  logic                           emit_free,
  output snfcs_pkg::emit_load_t          ld
);
  import snfcs_pkg::*;

  // Page and sector sizes are powers of two.
  localparam int PG_LOG = $clog2(PAGE_BYTES);
  localparam int CH_W   = PG_LOG + 1;
  localparam int SB_LOG = $clog2(SECTOR_BYTES);
  localparam int SC_W   = LEN_W - SB_LOG;
  localparam int LEFT_W = (SC_W > 16) ? SC_W : 16;

  // Input register.
  logic                 a_valid;
  logic [FUNC_W-1:0]    a_func;
  logic [ADDR_BITS-1:0] a_addr;
  logic [LEN_W-1:0]     a_len;
  logic [BYTE_W-1:0]    a_data;
  logic                 a_take;

  // Command state.
  phase_t               phase, phase_next;
  logic [ADDR_BITS-1:0] cur, cur_next;
  logic [LEFT_W-1:0]    left, left_next;
  logic [CH_W-1:0]      chunk, chunk_next;
  logic [1:0]           id_idx, id_idx_next;

  // Decoded values.
  logic [15:0]          sat16;
  logic [LEFT_W-1:0]    sat_w;
  logic [LEFT_W-1:0]    cnt_w;
  logic [LEFT_W-1:0]    left_dec;
  logic [CH_W-1:0]      chunk_dec;
  logic [ADDR_BITS-1:0] chk_addr;
  logic [LEFT_W-1:0]    chk_left;
  logic [CH_W-1:0]      pg_room;
  logic [CH_W-1:0]      chunk_new;
  logic [ADDR_W-1:0]    seq_a24;
  logic                 is_rx;
  logic                 busy;

  // Result list of the item in the input register.
  res_vec_t             list_c;
  logic [CNT_W-1:0]     n_c;
  logic                 done_c;

  function automatic res_t r_ctl(input logic [1:0] op, input logic done);
    res_t r;
    r       = '0;
    r.op    = op;
    r.done  = done;
    return r;
  endfunction

  function automatic res_t r_out(input logic [7:0] b);
    res_t r;
    r       = '0;
    r.op    = SPI_OUT;
    r.sbyte = b;
    return r;
  endfunction

  function automatic res_t r_host(input logic [1:0] op, input logic [2:0] hk,
                                  input logic [7:0] hb, input logic done);
    res_t r;
    r       = '0;
    r.op    = op;
    r.hkind = hk;
    r.hbyte = hb;
    r.done  = done;
    return r;
  endfunction

  // The item leaves the input register once its results fit in the queue.
  assign a_take   = a_valid && ((n_c == '0) || emit_free);
  assign in_ready = !a_valid || a_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_func <= func;
      a_addr <= address[ADDR_BITS-1:0];
      a_len  <= length;
      a_data <= data_byte;
    end
  end

  // Lengths, sector count and the size of the next page piece.
  assign sat16     = (|a_len[LEN_W-1:16]) ? LEN_SAT : a_len[15:0];
  assign sat_w     = LEFT_W'(sat16);
  assign cnt_w     = LEFT_W'(a_len[LEN_W-1:SB_LOG]);
  assign left_dec  = (left != '0) ? left - 1'b1 : left;
  assign chunk_dec = (chunk != '0) ? chunk - 1'b1 : chunk;
  assign chk_addr  = (phase == PH_IDLE) ? a_addr : cur;
  assign chk_left  = (phase == PH_IDLE) ? sat_w : left;
  assign pg_room   = CH_W'(PAGE_BYTES) - CH_W'(chk_addr[PG_LOG-1:0]);
  assign chunk_new = (LEFT_W'(pg_room) > chk_left) ? CH_W'(chk_left) : pg_room;
  assign seq_a24   = ADDR_W'(chk_addr);
  assign is_rx     = (a_func == FN_RX);
  assign busy      = a_data[STATUS_BUSY];

  // Next state.
  always_comb begin
    phase_next  = phase;
    cur_next    = cur;
    left_next   = left;
    chunk_next  = chunk;
    id_idx_next = id_idx;
    if (a_take) begin
      case (phase)
        PH_IDLE: begin
          case (a_func)
            FN_READ_ID: begin
              id_idx_next = '0;
              phase_next  = PH_ID;
            end
            FN_READ: begin
              cur_next  = a_addr;
              left_next = sat_w;
              if (sat_w != '0) phase_next = PH_READ;
            end
            FN_WRITE_START: begin
              if (sat_w != '0) begin
                cur_next   = a_addr;
                left_next  = sat_w;
                chunk_next = chunk_new;
                phase_next = PH_WDATA;
              end
            end
            FN_ERASE_SECTOR: begin
              cur_next   = a_addr;
              left_next  = '0;
              phase_next = PH_POLL_E;
            end
            FN_ERASE_AREA: begin
              if (cnt_w != '0) begin
                cur_next   = a_addr;
                left_next  = cnt_w - 1'b1;
                phase_next = PH_POLL_E;
              end
            end
            default: ;
          endcase
        end
        PH_ID: begin
          if (is_rx) begin
            if (id_idx == 2'd0) begin
              id_idx_next = 2'd1;
            end else if (id_idx == 2'd1) begin
              id_idx_next = 2'd2;
            end else begin
              id_idx_next = '0;
              phase_next  = PH_IDLE;
            end
          end
        end
        PH_READ: begin
          if (is_rx) begin
            left_next = left_dec;
            if (left_dec == '0) phase_next = PH_IDLE;
          end
        end
        PH_WDATA: begin
          if (a_func == FN_WRITE_BYTE) begin
            cur_next   = cur + 1'b1;
            left_next  = left_dec;
            chunk_next = chunk_dec;
            if (chunk_dec == '0) phase_next = PH_POLL_W;
          end
        end
        PH_POLL_W: begin
          if (is_rx && !busy) begin
            if (left == '0) begin
              phase_next = PH_IDLE;
            end else begin
              chunk_next = chunk_new;
              phase_next = PH_WDATA;
            end
          end
        end
        PH_POLL_E: begin
          if (is_rx && !busy) begin
            if (left == '0) begin
              phase_next = PH_IDLE;
            end else begin
              left_next  = left - 1'b1;
              cur_next   = cur + ADDR_BITS'(SECTOR_BYTES);
              phase_next = PH_WEL;
            end
          end
        end
        PH_WEL: begin
          if (is_rx) phase_next = PH_POLL_E;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Result list of the item waiting in the input register.
  always_comb begin
    list_c = '0;
    n_c    = '0;
    done_c = 1'b0;
    if (a_valid) begin
      case (phase)
        PH_IDLE: begin
          case (a_func)
            FN_READ_ID: begin
              list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
              list_c[n_c] = r_out(ops.rd_id);      n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_IN, 1'b0);   n_c = n_c + 1'b1;
            end
            FN_READ: begin
              list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
              list_c[n_c] = r_out(ops.rd);         n_c = n_c + 1'b1;
              list_c[n_c] = r_out(seq_a24[23:16]); n_c = n_c + 1'b1;
              list_c[n_c] = r_out(seq_a24[15:8]);  n_c = n_c + 1'b1;
              list_c[n_c] = r_out(seq_a24[7:0]);   n_c = n_c + 1'b1;
              if (sat_w == '0) begin
                list_c[n_c] = r_ctl(SPI_REL, 1'b1); n_c = n_c + 1'b1;
                done_c = 1'b1;
              end else begin
                list_c[n_c] = r_ctl(SPI_IN, 1'b0);  n_c = n_c + 1'b1;
              end
            end
            FN_WRITE_START: begin
              if (sat_w == '0) begin
                list_c[n_c] = r_ctl(SPI_REL, 1'b1); n_c = n_c + 1'b1;
                done_c = 1'b1;
              end else begin
                // Write enable, then the program header of the first piece.
                list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
                list_c[n_c] = r_out(ops.wen);        n_c = n_c + 1'b1;
                list_c[n_c] = r_ctl(SPI_REL, 1'b0);  n_c = n_c + 1'b1;
                list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
                list_c[n_c] = r_out(ops.pp);         n_c = n_c + 1'b1;
                list_c[n_c] = r_out(seq_a24[23:16]); n_c = n_c + 1'b1;
                list_c[n_c] = r_out(seq_a24[15:8]);  n_c = n_c + 1'b1;
                list_c[n_c] = r_out(seq_a24[7:0]);   n_c = n_c + 1'b1;
              end
            end
            FN_ERASE_SECTOR, FN_ERASE_AREA: begin
              if ((a_func == FN_ERASE_AREA) && (cnt_w == '0)) begin
                list_c[n_c] = r_ctl(SPI_REL, 1'b1); n_c = n_c + 1'b1;
                done_c = 1'b1;
              end else begin
                // Write enable, erase command, then the first status read.
                list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
                list_c[n_c] = r_out(ops.wen);        n_c = n_c + 1'b1;
                list_c[n_c] = r_ctl(SPI_REL, 1'b0);  n_c = n_c + 1'b1;
                list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
                list_c[n_c] = r_out(ops.se);         n_c = n_c + 1'b1;
                list_c[n_c] = r_out(seq_a24[23:16]); n_c = n_c + 1'b1;
                list_c[n_c] = r_out(seq_a24[15:8]);  n_c = n_c + 1'b1;
                list_c[n_c] = r_out(seq_a24[7:0]);   n_c = n_c + 1'b1;
                list_c[n_c] = r_ctl(SPI_REL, 1'b0);  n_c = n_c + 1'b1;
                list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
                list_c[n_c] = r_out(ops.rd_status);  n_c = n_c + 1'b1;
                list_c[n_c] = r_ctl(SPI_IN, 1'b0);   n_c = n_c + 1'b1;
              end
            end
            default: ;
          endcase
        end
        PH_ID: begin
          if (is_rx) begin
            if (id_idx == 2'd0) begin
              list_c[n_c] = r_host(SPI_IN, HK_MANUF, a_data, 1'b0);  n_c = n_c + 1'b1;
            end else if (id_idx == 2'd1) begin
              list_c[n_c] = r_host(SPI_IN, HK_DEV_HI, a_data, 1'b0); n_c = n_c + 1'b1;
            end else begin
              list_c[n_c] = r_host(SPI_REL, HK_DEV_LO, a_data, 1'b1); n_c = n_c + 1'b1;
              done_c = 1'b1;
            end
          end
        end
        PH_READ: begin
          if (is_rx) begin
            if (left_dec != '0) begin
              list_c[n_c] = r_host(SPI_IN, HK_DATA, a_data, 1'b0);  n_c = n_c + 1'b1;
            end else begin
              list_c[n_c] = r_host(SPI_REL, HK_DATA, a_data, 1'b1); n_c = n_c + 1'b1;
              done_c = 1'b1;
            end
          end
        end
        PH_WDATA: begin
          if (a_func == FN_WRITE_BYTE) begin
            list_c[n_c] = r_out(a_data); n_c = n_c + 1'b1;
            if (chunk_dec == '0) begin
              list_c[n_c] = r_ctl(SPI_REL, 1'b0); n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_SEL, 1'b0); n_c = n_c + 1'b1;
              list_c[n_c] = r_out(ops.rd_status); n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_IN, 1'b0);  n_c = n_c + 1'b1;
            end
          end
        end
        PH_POLL_W, PH_POLL_E: begin
          if (is_rx) begin
            if (busy) begin
              // Still busy: read the status again in the same select.
              list_c[n_c] = r_out(ops.rd_status); n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_IN, 1'b0);  n_c = n_c + 1'b1;
            end else if (left == '0) begin
              list_c[n_c] = r_ctl(SPI_REL, 1'b1); n_c = n_c + 1'b1;
              done_c = 1'b1;
            end else if (phase == PH_POLL_W) begin
              // Next page piece.
              list_c[n_c] = r_ctl(SPI_REL, 1'b0);  n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
              list_c[n_c] = r_out(ops.wen);        n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_REL, 1'b0);  n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
              list_c[n_c] = r_out(ops.pp);         n_c = n_c + 1'b1;
              list_c[n_c] = r_out(seq_a24[23:16]); n_c = n_c + 1'b1;
              list_c[n_c] = r_out(seq_a24[15:8]);  n_c = n_c + 1'b1;
              list_c[n_c] = r_out(seq_a24[7:0]);   n_c = n_c + 1'b1;
            end else begin
              // Next sector: write enable, then one paced status read.
              list_c[n_c] = r_ctl(SPI_REL, 1'b0); n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_SEL, 1'b0); n_c = n_c + 1'b1;
              list_c[n_c] = r_out(ops.wen);       n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_REL, 1'b0); n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_SEL, 1'b0); n_c = n_c + 1'b1;
              list_c[n_c] = r_out(ops.rd_status); n_c = n_c + 1'b1;
              list_c[n_c] = r_ctl(SPI_IN, 1'b0);  n_c = n_c + 1'b1;
            end
          end
        end
        PH_WEL: begin
          if (is_rx) begin
            list_c[n_c] = r_ctl(SPI_REL, 1'b0);  n_c = n_c + 1'b1;
            list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
            list_c[n_c] = r_out(ops.se);         n_c = n_c + 1'b1;
            list_c[n_c] = r_out(seq_a24[23:16]); n_c = n_c + 1'b1;
            list_c[n_c] = r_out(seq_a24[15:8]);  n_c = n_c + 1'b1;
            list_c[n_c] = r_out(seq_a24[7:0]);   n_c = n_c + 1'b1;
            list_c[n_c] = r_ctl(SPI_REL, 1'b0);  n_c = n_c + 1'b1;
            list_c[n_c] = r_ctl(SPI_SEL, 1'b0);  n_c = n_c + 1'b1;
            list_c[n_c] = r_out(ops.rd_status);  n_c = n_c + 1'b1;
            list_c[n_c] = r_ctl(SPI_IN, 1'b0);   n_c = n_c + 1'b1;
          end
        end
        default: ;
      endcase
      if (n_c != '0) list_c[n_c - 1'b1].last = 1'b1;
    end
  end

  assign ld.load = a_take && (n_c != '0);
  assign ld.cnt  = n_c;
  assign ld.list = list_c;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      cur    <= '0;
      left   <= '0;
      chunk  <= '0;
      id_idx <= '0;
    end else begin
      phase  <= phase_next;
      cur    <= cur_next;
      left   <= left_next;
      chunk  <= chunk_next;
      id_idx <= id_idx_next;
    end
  end

  `SNFCS_ASSERT_NXT(a_hold_phase, !a_take, phase == $past(phase), "phase moved without an item")
  `SNFCS_ASSERT_IMP(a_chunk_live, phase == PH_WDATA, chunk != '0, "empty page piece in data phase")
  `SNFCS_ASSERT_NXT(a_done_idle, ld.load && done_c, phase == PH_IDLE, "command done but not idle")

endmodule

/* rtl/snfcs_emit.sv */
// Result queue: holds the result beats of one item and sends them in order.
// Depends on snfcs_pkg and the assertion macro header.
`include "spi_nor_flash_command_sequencer_macros.svh"

module snfcs_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  snfcs_pkg::emit_load_t         ld,
  output logic                          emit_free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    spi_op,
  output logic [snfcs_pkg::BYTE_W-1:0]  spi_byte,
  output logic [2:0]                    host_kind,
  output logic [snfcs_pkg::BYTE_W-1:0]  host_byte,
  output logic                          cmd_done,
  output logic                          last
);
  import snfcs_pkg::*;

  res_vec_t         q;
  logic [CNT_W-1:0] cnt;
  logic             pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && out_ready;
  // Room for a new list once the last held beat leaves this cycle.
  assign emit_free = (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ld.load) begin
      cnt <= ld.cnt;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Beats shift down towards entry zero, which drives the ports.
  always_ff @(posedge clk) begin
    if (ld.load) begin
      q <= ld.list;
    end else if (pop) begin
      q <= res_vec_t'(q >> RES_W);
    end
  end

  assign spi_op    = q[0].op;
  assign spi_byte  = q[0].sbyte;
  assign host_kind = q[0].hkind;
  assign host_byte = q[0].hbyte;
  assign cmd_done  = q[0].done;
  assign last      = q[0].last;

  `SNFCS_ASSERT_IMP(a_load_room, ld.load, (cnt == '0) || ((cnt == CNT_W'(1)) && out_ready), "queue overwritten")
  `SNFCS_ASSERT_NXT(a_pop_count, pop && !ld.load, cnt == $past(cnt) - 1'b1, "beat count slipped")
  `SNFCS_ASSERT_IMP(a_last_mark, cnt != '0, q[0].last == (cnt == CNT_W'(1)), "last mark misplaced")

endmodule

/* rtl/spi_nor_flash_command_sequencer.sv */
// Top level of the SPI NOR flash command sequencer: opcode registers and wiring.
// Depends on snfcs_pkg, snfcs_seq and snfcs_emit.
//
//   Channel  Dir  Handshake               Payload
//   in       in   in_valid / in_ready     func, address, length, data_byte
//   out      out  out_valid / out_ready   spi_op, spi_byte, host_kind, host_byte,
//                                         cmd_done, last
//   cfg      in   cfg_we                  cfg_idx, cfg_wdata
//
// An accepted item waits in the input register, where its list of result beats is
// formed; the list moves into the result queue once the queue has room, and the first
// beat shows from the queue. Results leave one beat per cycle while out_ready is high;
// an item with no result is dropped with no beat. The result queue sets the rate.
// rst clears the phase, counters and queue, and loads the standard opcodes.
// With out_ready low the queue holds, and one more item waits in the input register.

module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES   = snfcs_pkg::DEF_PAGE_BYTES,
  parameter int SECTOR_BYTES = snfcs_pkg::DEF_SECTOR_BYTES,
  parameter int ADDR_BITS    = snfcs_pkg::DEF_ADDR_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_idx,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [snfcs_pkg::FUNC_W-1:0]  func,
  input  logic [snfcs_pkg::ADDR_W-1:0]  address,
  input  logic [snfcs_pkg::LEN_W-1:0]   length,
  input  logic [snfcs_pkg::BYTE_W-1:0]  data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    spi_op,
  output logic [snfcs_pkg::BYTE_W-1:0]  spi_byte,
  output logic [2:0]                    host_kind,
  output logic [snfcs_pkg::BYTE_W-1:0]  host_byte,
  output logic                          cmd_done,
  output logic                          last
);
  import snfcs_pkg::*;

  op_regs_t   ops;
  emit_load_t ld;
  logic       emit_free;

  // Opcode registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      ops.rd_id     <= DEF_OP_READ_ID;
      ops.rd_status <= DEF_OP_READ_STATUS;
      ops.rd        <= DEF_OP_READ;
      ops.wen       <= DEF_OP_WRITE_EN;
      ops.pp        <= DEF_OP_PAGE_PROG;
      ops.se        <= DEF_OP_SECTOR_ERA;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OP_READ_ID:     ops.rd_id     <= cfg_wdata;
        REG_OP_READ_STATUS: ops.rd_status <= cfg_wdata;
        REG_OP_READ:        ops.rd        <= cfg_wdata;
        REG_OP_WRITE_EN:    ops.wen       <= cfg_wdata;
        REG_OP_PAGE_PROG:   ops.pp        <= cfg_wdata;
        REG_OP_SECTOR_ERA:  ops.se        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  snfcs_seq #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .ops       (ops),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .address   (address),
    .length    (length),
    .data_byte (data_byte),
    .emit_free (emit_free),
    .ld        (ld)
  );

  snfcs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .emit_free (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .spi_op    (spi_op),
    .spi_byte  (spi_byte),
    .host_kind (host_kind),
    .host_byte (host_byte),
    .cmd_done  (cmd_done),
    .last      (last)
  );

endmodule

/* dv/spi_nor_flash_command_sequencer_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the SPI NOR flash command sequencer: directed and random
// host commands and flash replies, each result beat checked against an in-bench model.
// Depends on snfcs_pkg and the spi_nor_flash_command_sequencer RTL.

module spi_nor_flash_command_sequencer_test;
  import snfcs_pkg::*;

  localparam int          PAGE        = DEF_PAGE_BYTES;
  localparam int          SECTOR      = DEF_SECTOR_BYTES;
  localparam logic [23:0] SECTOR_STEP = 24'(DEF_SECTOR_BYTES);
  localparam logic [24:0] LEN_TOP     = 25'h1000000;
  localparam logic [2:0]  FN_UNUSED   = 3'd7;
  localparam int          MAX_CYCLES  = 3_000_000;
  localparam int          HOLD_OFF    = 120;
  localparam int          DRAIN       = 8;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [2:0]           cfg_idx;
  logic [7:0]           cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [FUNC_W-1:0]    func;
  logic [ADDR_W-1:0]    address;
  logic [LEN_W-1:0]     length;
  logic [BYTE_W-1:0]    data_byte;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           spi_op;
  logic [BYTE_W-1:0]    spi_byte;
  logic [2:0]           host_kind;
  logic [BYTE_W-1:0]    host_byte;
  logic                 cmd_done;
  logic                 last;

  // Model of the sequencer: phase, counters and opcodes.
  phase_t               seq_phase;
  logic [23:0]          seq_addr;
  logic [23:0]          seq_left;
  logic [8:0]           seq_chunk;
  logic [1:0]           seq_id_idx;
  op_regs_t             seq_ops;

  // SPI actions still owed by the block, and those of the item just accepted.
  res_t                 actions_due[$];
  res_t                 step_actions[$];
  int                   step_count;

  int                   send_idle_pct;
  int                   recv_stall_pct;
  bit                   hold_req;
  int                   hold_left;
  int                   fail_count;
  int                   cycle_count;

  spi_nor_flash_command_sequencer DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void push_action(logic [1:0] op, logic [7:0] sb, logic [2:0] hk,
                                      logic [7:0] hb, logic done);
    res_t r;
    r.op    = op;
    r.sbyte = sb;
    r.hkind = hk;
    r.hbyte = hb;
    r.done  = done;
    r.last  = 1'b0;
    step_actions.push_back(r);
  endfunction

  function automatic void spi_action(logic [1:0] op, logic [7:0] sb);
    push_action(op, sb, HK_NONE, 8'h00, 1'b0);
  endfunction

  function automatic void send_address();
    spi_action(SPI_OUT, seq_addr[23:16]);
    spi_action(SPI_OUT, seq_addr[15:8]);
    spi_action(SPI_OUT, seq_addr[7:0]);
  endfunction

  function automatic void start_status_poll();
    spi_action(SPI_SEL, 8'h00);
    spi_action(SPI_OUT, seq_ops.rd_status);
    spi_action(SPI_IN, 8'h00);
  endfunction

  // A program chunk never crosses a page boundary.
  function automatic void open_page_chunk();
    int room;
    room = PAGE - (seq_addr % PAGE);
    if (room > seq_left) room = seq_left;
    seq_chunk = 9'(room);
    spi_action(SPI_SEL, 8'h00);
    spi_action(SPI_OUT, seq_ops.wen);
    spi_action(SPI_REL, 8'h00);
    spi_action(SPI_SEL, 8'h00);
    spi_action(SPI_OUT, seq_ops.pp);
    send_address();
    seq_phase = PH_WDATA;
  endfunction

  function automatic void issue_sector_erase();
    spi_action(SPI_SEL, 8'h00);
    spi_action(SPI_OUT, seq_ops.se);
    send_address();
    spi_action(SPI_REL, 8'h00);
    start_status_poll();
    seq_phase = PH_POLL_E;
  endfunction

  // Works out the SPI actions that one accepted item causes and queues them.
  function automatic void sequence_command(logic [2:0] f, logic [23:0] a, logic [24:0] l,
                                           logic [7:0] d);
    logic [23:0] sat;
    logic [24:0] sectors;
    res_t        r;
    sat = (l > {9'h000, LEN_SAT}) ? {8'h00, LEN_SAT} : l[23:0];
    sectors = l / SECTOR;
    step_actions.delete();
    case (seq_phase)
      PH_IDLE: begin
        if (f == FN_READ_ID) begin
          spi_action(SPI_SEL, 8'h00);
          spi_action(SPI_OUT, seq_ops.rd_id);
          spi_action(SPI_IN, 8'h00);
          seq_id_idx = 2'd0;
          seq_phase = PH_ID;
        end else if (f == FN_READ) begin
          seq_addr = a;
          seq_left = sat;
          spi_action(SPI_SEL, 8'h00);
          spi_action(SPI_OUT, seq_ops.rd);
          send_address();
          if (sat == 0) begin
            push_action(SPI_REL, 8'h00, HK_NONE, 8'h00, 1'b1);
          end else begin
            spi_action(SPI_IN, 8'h00);
            seq_phase = PH_READ;
          end
        end else if (f == FN_WRITE_START) begin
          if (sat == 0) begin
            push_action(SPI_REL, 8'h00, HK_NONE, 8'h00, 1'b1);
          end else begin
            seq_addr = a;
            seq_left = sat;
            open_page_chunk();
          end
        end else if (f == FN_ERASE_SECTOR || (f == FN_ERASE_AREA && sectors != 0)) begin
          seq_addr = a;
          seq_left = (f == FN_ERASE_AREA) ? 24'(sectors - 1) : 24'h000000;
          spi_action(SPI_SEL, 8'h00);
          spi_action(SPI_OUT, seq_ops.wen);
          spi_action(SPI_REL, 8'h00);
          issue_sector_erase();
        end else if (f == FN_ERASE_AREA) begin
          push_action(SPI_REL, 8'h00, HK_NONE, 8'h00, 1'b1);
        end
      end
      PH_ID: begin
        if (f == FN_RX) begin
          if (seq_id_idx == 2'd0) begin
            push_action(SPI_IN, 8'h00, HK_MANUF, d, 1'b0);
            seq_id_idx = 2'd1;
          end else if (seq_id_idx == 2'd1) begin
            push_action(SPI_IN, 8'h00, HK_DEV_HI, d, 1'b0);
            seq_id_idx = 2'd2;
          end else begin
            push_action(SPI_REL, 8'h00, HK_DEV_LO, d, 1'b1);
            seq_id_idx = 2'd0;
            seq_phase = PH_IDLE;
          end
        end
      end
      PH_READ: begin
        if (f == FN_RX) begin
          if (seq_left > 0) seq_left = seq_left - 1;
          if (seq_left > 0) begin
            push_action(SPI_IN, 8'h00, HK_DATA, d, 1'b0);
          end else begin
            push_action(SPI_REL, 8'h00, HK_DATA, d, 1'b1);
            seq_phase = PH_IDLE;
          end
        end
      end
      PH_WDATA: begin
        if (f == FN_WRITE_BYTE) begin
          spi_action(SPI_OUT, d);
          seq_addr = seq_addr + 24'h000001;
          if (seq_left > 0) seq_left = seq_left - 1;
          if (seq_chunk > 0) seq_chunk = seq_chunk - 1;
          if (seq_chunk == 0) begin
            spi_action(SPI_REL, 8'h00);
            start_status_poll();
            seq_phase = PH_POLL_W;
          end
        end
      end
      PH_POLL_W, PH_POLL_E: begin
        if (f == FN_RX) begin
          if (d[STATUS_BUSY]) begin
            spi_action(SPI_OUT, seq_ops.rd_status);
            spi_action(SPI_IN, 8'h00);
          end else if (seq_left == 0) begin
            push_action(SPI_REL, 8'h00, HK_NONE, 8'h00, 1'b1);
            seq_phase = PH_IDLE;
          end else if (seq_phase == PH_POLL_W) begin
            spi_action(SPI_REL, 8'h00);
            open_page_chunk();
          end else begin
            // Next sector: write enable, then one paced status read.
            seq_left = seq_left - 1;
            seq_addr = seq_addr + SECTOR_STEP;
            spi_action(SPI_REL, 8'h00);
            spi_action(SPI_SEL, 8'h00);
            spi_action(SPI_OUT, seq_ops.wen);
            spi_action(SPI_REL, 8'h00);
            start_status_poll();
            seq_phase = PH_WEL;
          end
        end
      end
      PH_WEL: begin
        if (f == FN_RX) begin
          spi_action(SPI_REL, 8'h00);
          issue_sector_erase();
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    step_count = step_actions.size();
    if (step_count > 0) begin
      r = step_actions.pop_back();
      r.last = 1'b1;
      step_actions.push_back(r);
    end
    foreach (step_actions[i]) actions_due.push_back(step_actions[i]);
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offers one item after a random gap and updates the model once it is accepted.
  task automatic send_item(input logic [2:0] f, input logic [23:0] a, input logic [24:0] l,
                           input logic [7:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    address   <= a;
    length    <= l;
    data_byte <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sequence_command(f, a, l, d);
  endtask

  // Waits until every owed beat has arrived and the input register has emptied.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (actions_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_opcodes(input op_regs_t ops);
    wait_for_idle();
    write_reg(REG_OP_READ_ID, ops.rd_id);
    write_reg(REG_OP_READ_STATUS, ops.rd_status);
    write_reg(REG_OP_READ, ops.rd);
    write_reg(REG_OP_WRITE_EN, ops.wen);
    write_reg(REG_OP_PAGE_PROG, ops.pp);
    write_reg(REG_OP_SECTOR_ERA, ops.se);
    cfg_we <= 1'b0;
    seq_ops = ops;
  endtask

  // An item that the current phase does not await, with random fields.
  task automatic send_noise();
    logic [2:0] f;
    logic [2:0] awaited;
    if (seq_phase == PH_IDLE) begin
      case ($urandom_range(0, 2))
        0:       f = FN_WRITE_BYTE;
        1:       f = FN_RX;
        default: f = FN_UNUSED;
      endcase
    end else begin
      awaited = (seq_phase == PH_WDATA) ? FN_WRITE_BYTE : FN_RX;
      f = 3'($urandom());
      while (f == awaited) f = 3'($urandom());
    end
    send_item(f, 24'($urandom()), 25'($urandom_range(0, LEN_TOP)), 8'($urandom()));
  endtask

  // A new host command with small lengths so that every command completes quickly.
  task automatic send_random_command();
    logic [23:0] a;
    logic [24:0] any_len;
    logic [7:0]  d;
    a = 24'($urandom());
    any_len = 25'($urandom_range(0, LEN_TOP));
    d = 8'($urandom());
    case ($urandom_range(0, 4))
      0: send_item(FN_READ_ID, a, any_len, d);
      1: send_item(FN_READ, a, 25'($urandom_range(0, 6)), d);
      2: begin
        if ($urandom_range(0, 1) == 1) a[7:0] = 8'hF0 | 8'($urandom_range(0, 15));
        send_item(FN_WRITE_START, a, 25'($urandom_range(0, 24)), d);
      end
      3: send_item(FN_ERASE_SECTOR, a, any_len, d);
      default: send_item(FN_ERASE_AREA, a, 25'($urandom_range(0, 4 * SECTOR - 1)), d);
    endcase
  endtask

  // The item the current phase awaits: a write byte or a byte from the flash.
  task automatic continue_command();
    logic [7:0] d;
    d = 8'($urandom());
    if (seq_phase == PH_WDATA) begin
      send_item(FN_WRITE_BYTE, 24'($urandom()), 25'($urandom_range(0, LEN_TOP)), d);
    end else begin
      if (seq_phase == PH_POLL_W || seq_phase == PH_POLL_E)
        d[STATUS_BUSY] = ($urandom_range(0, 2) == 0);
      send_item(FN_RX, 24'($urandom()), 25'($urandom_range(0, LEN_TOP)), d);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    // Items in the wrong phase are dropped.
    send_item(FN_UNUSED, 24'hFFFFFF, LEN_TOP, 8'hFF);
    // Identifier read, with a stray command in the middle.
    send_item(FN_READ_ID, 24'h000000, LEN_TOP, 8'h00);
    send_item(FN_READ, 24'h123456, 25'd4, 8'h00);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h00);
    send_item(FN_RX, 24'h000000, 25'd0, 8'hFF);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h5A);
    // Zero-length read, then a two-byte read at the top of the address space.
    send_item(FN_READ, 24'h000000, 25'd0, 8'h00);
    send_item(FN_READ, 24'hFFFFFF, 25'd2, 8'h00);
    send_item(FN_RX, 24'h000000, 25'd0, 8'hFF);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h00);
    // Empty write and an area shorter than one sector.
    send_item(FN_WRITE_START, 24'h000100, 25'd0, 8'h00);
    send_item(FN_ERASE_AREA, 24'h000000, 25'd4095, 8'h00);
    // Write crossing a page boundary and wrapping the address.
    send_item(FN_WRITE_START, 24'hFFFFFE, 25'd3, 8'h00);
    send_item(FN_WRITE_BYTE, 24'h000000, 25'd0, 8'hFF);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h01);
    send_item(FN_WRITE_BYTE, 24'h000000, 25'd0, 8'h00);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h01);
    send_item(FN_RX, 24'h000000, 25'd0, 8'hFE);
    send_item(FN_WRITE_BYTE, 24'h000000, 25'd0, 8'hA5);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h00);
    // Single sector erase with one busy status.
    send_item(FN_ERASE_SECTOR, 24'hABCDEF, 25'd0, 8'h00);
    send_item(FN_RX, 24'h000000, 25'd0, 8'hFF);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h00);
    // Two-sector area erase wrapping past the top of the address space.
    send_item(FN_ERASE_AREA, 24'hFFF000, 25'd8192, 8'h00);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h00);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h01);
    send_item(FN_RX, 24'h000000, 25'd0, 8'h00);
  endtask

  // Mostly complete command sequences with random content, some stray items.
  task automatic run_random_commands(input int n);
    int taken;
    taken = 0;
    while (taken < n) begin
      if ($urandom_range(0, 99) < 12) send_noise();
      else if (seq_phase == PH_IDLE) send_random_command();
      else continue_command();
      if (step_count > 0) taken++;
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_output_stall();
    hold_req = 1'b1;
    run_random_commands(30);
  endtask

  // Read and write lengths above the limit are clamped.
  task automatic test_length_saturation();
    send_item(FN_READ, 24'($urandom()), LEN_TOP, 8'($urandom()));
    while (seq_phase != PH_IDLE) continue_command();
    send_item(FN_WRITE_START, 24'($urandom()), 25'd65536, 8'($urandom()));
    while (seq_phase != PH_IDLE) continue_command();
  endtask

  // ---------------------------------------------------------------- receiver and checker

  // Drives out_ready; a requested hold-off is counted down here.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Each result beat is compared with the oldest owed action.
  always @(posedge clk) begin : check_beats
    res_t due;
    if (!rst && out_valid && out_ready) begin
      if (actions_due.size() == 0) begin
        $error("unexpected beat: spi_op %0d spi_byte 0x%0h host_kind %0d", spi_op, spi_byte,
               host_kind);
        fail_count++;
      end else begin
        due = actions_due.pop_front();
        check_field("spi_op", due.op, spi_op);
        check_field("spi_byte", due.sbyte, spi_byte);
        check_field("host_kind", due.hkind, host_kind);
        check_field("host_byte", due.hbyte, host_byte);
        check_field("cmd_done", due.done, cmd_done);
        check_field("last", due.last, last);
      end
    end
  end

  // Guard against a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- sequence of tests

  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_idx    = REG_OP_READ_ID;
    cfg_wdata  = 8'h00;
    in_valid   = 1'b0;
    func       = FN_READ_ID;
    address    = '0;
    length     = '0;
    data_byte  = '0;
    hold_req   = 1'b0;
    hold_left  = 0;
    fail_count = 0;
    step_count = 0;
    seq_phase  = PH_IDLE;
    seq_addr   = '0;
    seq_left   = '0;
    seq_chunk  = '0;
    seq_id_idx = '0;
    seq_ops    = '{rd_id: DEF_OP_READ_ID, rd_status: DEF_OP_READ_STATUS, rd: DEF_OP_READ,
                   wen: DEF_OP_WRITE_EN, pp: DEF_OP_PAGE_PROG, se: DEF_OP_SECTOR_ERA};

    // Sender mostly busy, receiver mostly stalling.
    send_idle_pct  = 11;
    recv_stall_pct = 62;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    run_random_commands(45);

    // Sender mostly idle, receiver mostly ready; all opcodes at their top value.
    write_opcodes('1);
    send_idle_pct  = 62;
    recv_stall_pct = 11;
    run_random_commands(45);
    test_output_stall();

    // No idling on either side; zero opcodes, then random ones.
    write_opcodes('0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_commands(25);
    write_opcodes({16'($urandom()), $urandom()});
    run_random_commands(25);
    test_length_saturation();

    wait_for_idle();
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/snfcs_pkg.sv
rtl/snfcs_seq.sv
rtl/snfcs_emit.sv
rtl/spi_nor_flash_command_sequencer.sv
dv/spi_nor_flash_command_sequencer_test.sv
